// ===== hdl/nfa_best_inlier_count_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef NFA_BEST_INLIER_COUNT_CORE_DEFINES_SVH
`define NFA_BEST_INLIER_COUNT_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define NFA_BIC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nfa_bic check failed");

// Next-cycle implication, quiet during reset.
`define NFA_BIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nfa_bic check failed");

// Next-cycle implication that also holds through reset.
`define NFA_BIC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("nfa_bic check failed");

`endif

// ===== hdl/nfa_bic_pkg.sv =====
package nfa_bic_pkg;

   localparam int MAX_POINTS  = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam int ERR_W    = 32;
   localparam int COMB_W   = 27;
   localparam int ALPHA_W  = 23;
   localparam int E0_W     = 20;
   localparam int SS_W     = 5;
   localparam int LOG_W    = 21;
   localparam int LALPHA_W = 24;
   localparam int BASE_W   = 29;
   localparam int NFA_W    = 48;
   localparam int SUM_W    = 49;

   localparam int REQ_TDATA_W = ((ERR_W + 2 * COMB_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [LOG_W-1:0] LOG10_2_Q16 = 21'sd19728;

   localparam logic signed [NFA_W-1:0] NFA_MAX = {1'b0, {(NFA_W-1){1'b1}}};
   localparam logic signed [NFA_W-1:0] NFA_MIN = {1'b1, {(NFA_W-1){1'b0}}};

   localparam logic signed [ALPHA_W-1:0] ALPHA_RESET     = -23'sd262144;
   localparam logic                      HALF_RESET      = 1'b1;
   localparam logic [SS_W-1:0]           SS_RESET        = 5'd7;
   localparam logic [E0_W-1:0]           E0_RESET        = 20'd131072;
   localparam logic [ERR_W-1:0]          THRESHOLD_RESET = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      REG_ALPHA_LEFT    = 3'd0,
      REG_ALPHA_RIGHT   = 3'd1,
      REG_HALF_WEIGHT   = 3'd2,
      REG_SAMPLE_SIZE   = 3'd3,
      REG_LOG_E0        = 3'd4,
      REG_MAX_THRESHOLD = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [ALPHA_W-1:0] alpha_left;
      logic signed [ALPHA_W-1:0] alpha_right;
      logic                      half_weight;
      logic [SS_W-1:0]           sample_size;
      logic [E0_W-1:0]           log_e0;
      logic [ERR_W-1:0]          max_threshold;
   } cfg_type;

   typedef struct packed {
      logic eval;
      logic last;
      logic side;
   } item_ctl_type;

   localparam int CTL_W = $bits(item_ctl_type);

   // round(65536 * log10(1 + i/16))
   function automatic logic [15:0] log_mant(input logic [3:0] idx);
      logic [15:0] v;
      unique case (idx)
         4'd0:    v = 16'd0;
         4'd1:    v = 16'd1725;
         4'd2:    v = 16'd3352;
         4'd3:    v = 16'd4891;
         4'd4:    v = 16'd6351;
         4'd5:    v = 16'd7740;
         4'd6:    v = 16'd9064;
         4'd7:    v = 16'd10329;
         4'd8:    v = 16'd11540;
         4'd9:    v = 16'd12702;
         4'd10:   v = 16'd13818;
         4'd11:   v = 16'd14893;
         4'd12:   v = 16'd15928;
         4'd13:   v = 16'd16927;
         4'd14:   v = 16'd17891;
         default: v = 16'd18825;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/nfa_bic_front.sv =====
module nfa_bic_front #(
   parameter int MAX_POINTS = nfa_bic_pkg::MAX_POINTS,
   parameter int POS_W      = $clog2(MAX_POINTS + 1),
   parameter int Q_W        = nfa_bic_pkg::CTL_W + nfa_bic_pkg::LALPHA_W + POS_W
                              + 2 * nfa_bic_pkg::COMB_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nfa_bic_pkg::cfg_type                  cfg,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [nfa_bic_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   input  logic                                  q_full,
   output logic                                  q_push,
   output logic [Q_W-1:0]                        q_wdata
);

   localparam int ERR_W  = nfa_bic_pkg::ERR_W;
   localparam int COMB_W = nfa_bic_pkg::COMB_W;
   localparam int SS_W   = nfa_bic_pkg::SS_W;
   localparam int LOG_W  = nfa_bic_pkg::LOG_W;
   localparam int LA_W   = nfa_bic_pkg::LALPHA_W;
   localparam int X_W    = ERR_W + 1;

   // set tracking
   logic [POS_W-1:0] position_ff, position_in;
   logic             past_ff, past_in;

   // first front stage
   logic                      f1_valid_ff, f1_valid_in;
   nfa_bic_pkg::item_ctl_type f1_ctl_ff;
   logic [X_W-1:0]            f1_x_ff;
   logic [POS_W-1:0]          f1_mult_ff;
   logic [COMB_W-1:0]         f1_lcn_ff, f1_lck_ff;

   logic                      accept;
   logic [ERR_W-1:0]          err;
   logic                      in_range, past_now, eval;
   logic [POS_W-1:0]          k, mult;
   nfa_bic_pkg::item_ctl_type ctl;

   logic [5:0]                lead;
   logic [X_W+3:0]            norm;
   logic signed [6:0]         expo;
   logic signed [LOG_W-1:0]   lg, lg_w;
   logic signed [LA_W-1:0]    log_alpha;

   assign req_tready = !f1_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = f1_valid_ff && !q_full;

   always_comb begin
      err      = req_tdata[ERR_W-1:0];
      in_range = position_ff < POS_W'(MAX_POINTS);
      k        = position_ff + POS_W'(1);
      past_now = past_ff || (err > cfg.max_threshold);
      eval     = in_range && !past_now
                 && ({{SS_W{1'b0}}, k} > {{POS_W{1'b0}}, cfg.sample_size});
      mult     = POS_W'({{SS_W{1'b0}}, k} - {{POS_W{1'b0}}, cfg.sample_size});
      ctl.eval = eval;
      ctl.last = req_tlast;
      ctl.side = req_tuser;

      position_in = position_ff;
      past_in     = past_ff;
      if (accept) begin
         if (req_tlast) begin
            position_in = '0;
            past_in     = 1'b0;
         end else if (in_range) begin
            position_in = k;
            past_in     = past_now;
         end
      end

      f1_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : f1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         past_ff     <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else begin
         position_ff <= position_in;
         past_ff     <= past_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_ctl_ff  <= ctl;
         f1_x_ff    <= {1'b0, err} + X_W'(1);
         f1_mult_ff <= mult;
         f1_lcn_ff  <= req_tdata[ERR_W +: COMB_W];
         f1_lck_ff  <= req_tdata[ERR_W+COMB_W +: COMB_W];
      end
   end

   // log10 by leading one plus 4-bit mantissa lookup
   always_comb begin
      lead = '0;
      for (int i = 0; i < X_W; i++) begin
         if (f1_x_ff[i]) lead = 6'(i);
      end
      norm = {f1_x_ff, 4'b0000} >> lead;
      expo = $signed({1'b0, lead}) - 7'sd16;
      lg   = LOG_W'(expo) * nfa_bic_pkg::LOG10_2_Q16
             + $signed({5'b00000, nfa_bic_pkg::log_mant(norm[3:0])});
      lg_w = cfg.half_weight ? (lg >>> 1) : lg;
      log_alpha = (f1_ctl_ff.side ? LA_W'(cfg.alpha_right) : LA_W'(cfg.alpha_left))
                  + LA_W'(lg_w);
   end

   assign q_wdata = {f1_ctl_ff, log_alpha, f1_mult_ff, f1_lcn_ff, f1_lck_ff};

endmodule

// ===== hdl/nfa_bic_queue.sv =====
module nfa_bic_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nfa_bic_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wdata;
   end

endmodule

// ===== hdl/nfa_bic_back.sv =====
module nfa_bic_back #(
   parameter int MAX_POINTS = nfa_bic_pkg::MAX_POINTS,
   parameter int POS_W      = $clog2(MAX_POINTS + 1),
   parameter int Q_W        = nfa_bic_pkg::CTL_W + nfa_bic_pkg::LALPHA_W + POS_W
                              + 2 * nfa_bic_pkg::COMB_W,
   parameter int RSP_W      = ((nfa_bic_pkg::NFA_W + POS_W + 2 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nfa_bic_pkg::cfg_type cfg,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic [Q_W-1:0]       q_rdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata
);

   localparam int COMB_W = nfa_bic_pkg::COMB_W;
   localparam int LA_W   = nfa_bic_pkg::LALPHA_W;
   localparam int BASE_W = nfa_bic_pkg::BASE_W;
   localparam int NFA_W  = nfa_bic_pkg::NFA_W;
   localparam int SUM_W  = nfa_bic_pkg::SUM_W;
   localparam int PROD_W = LA_W + POS_W + 1;

   nfa_bic_pkg::item_ctl_type q_ctl;
   logic signed [LA_W-1:0]    q_log_alpha;
   logic [POS_W-1:0]          q_mult;
   logic [COMB_W-1:0]         q_lcn, q_lck;

   logic                      b1_valid_ff, b1_valid_in;
   nfa_bic_pkg::item_ctl_type b1_ctl_ff;
   logic signed [PROD_W-1:0]  b1_prod_ff;
   logic [BASE_W-1:0]         b1_base_ff;

   logic                      b2_valid_ff, b2_valid_in;
   nfa_bic_pkg::item_ctl_type b2_ctl_ff;
   logic signed [NFA_W-1:0]   b2_nfa_ff;

   logic                      have_ff, have_in;
   logic signed [NFA_W-1:0]   min_nfa_ff, min_nfa_in;
   logic [POS_W-1:0]          min_pos_ff, min_pos_in;
   logic                      min_side_ff, min_side_in;
   // position of each item, tracked alongside to name the minimum
   logic [POS_W-1:0]          b_pos_ff, b_pos_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   logic                      stall, consume;
   logic signed [SUM_W-1:0]   sum;
   logic signed [NFA_W-1:0]   nfa_sat;
   logic                      better, nh;
   logic signed [NFA_W-1:0]   nmin;
   logic [POS_W-1:0]          npos, kpos;
   logic                      nside;

   assign {q_ctl, q_log_alpha, q_mult, q_lcn, q_lck} = q_rdata;

   // only a finished set waiting on a full output holds the pipeline
   assign stall   = b2_valid_ff && b2_ctl_ff.last && rsp_valid_ff && !rsp_tready;
   assign q_pop   = !q_empty && !stall;
   assign consume = b2_valid_ff && !stall;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      sum = SUM_W'(b1_prod_ff) + $signed({{(SUM_W-BASE_W){1'b0}}, b1_base_ff});
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         nfa_sat = sum[SUM_W-1] ? nfa_bic_pkg::NFA_MIN : nfa_bic_pkg::NFA_MAX;
      end else begin
         nfa_sat = sum[NFA_W-1:0];
      end

      b1_valid_in = stall ? b1_valid_ff : q_pop;
      b2_valid_in = stall ? b2_valid_ff : b1_valid_ff;
   end

   // min tracking and result build
   always_comb begin
      kpos   = (b_pos_ff < POS_W'(MAX_POINTS)) ? b_pos_ff + POS_W'(1) : b_pos_ff;
      better = b2_ctl_ff.eval && (!have_ff || (b2_nfa_ff < min_nfa_ff));
      nh     = have_ff || b2_ctl_ff.eval;
      nmin   = better ? b2_nfa_ff : min_nfa_ff;
      npos   = better ? kpos : min_pos_ff;
      nside  = better ? b2_ctl_ff.side : min_side_ff;

      have_in     = have_ff;
      min_nfa_in  = min_nfa_ff;
      min_pos_in  = min_pos_ff;
      min_side_in = min_side_ff;
      b_pos_in    = b_pos_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (consume) begin
         if (b2_ctl_ff.last) begin
            have_in      = 1'b0;
            min_nfa_in   = '0;
            min_pos_in   = '0;
            min_side_in  = 1'b0;
            b_pos_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in[0] = nh;
            rsp_data_in[NFA_W:1] = nh ? nmin : '0;
            rsp_data_in[NFA_W+1 +: POS_W] = nh ? npos : POS_W'(cfg.sample_size);
            rsp_data_in[NFA_W+1+POS_W] = nh ? nside : 1'b0;
         end else begin
            have_in     = nh;
            min_nfa_in  = nmin;
            min_pos_in  = npos;
            min_side_in = nside;
            b_pos_in    = kpos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         min_nfa_ff   <= '0;
         min_pos_ff   <= '0;
         min_side_ff  <= 1'b0;
         b_pos_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         have_ff      <= have_in;
         min_nfa_ff   <= min_nfa_in;
         min_pos_ff   <= min_pos_in;
         min_side_ff  <= min_side_in;
         b_pos_ff     <= b_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (!stall) begin
         b1_ctl_ff  <= q_ctl;
         b1_prod_ff <= q_log_alpha * $signed({1'b0, q_mult});
         b1_base_ff <= BASE_W'(q_lcn) + BASE_W'(q_lck) + BASE_W'(cfg.log_e0);
         b2_ctl_ff  <= b1_ctl_ff;
         b2_nfa_ff  <= nfa_sat;
      end
   end

endmodule

// ===== hdl/nfa_best_inlier_count_core.sv =====
// A result is registered on rsp_tvalid after the transaction carrying tlast has passed the
// front stage, the queue and the two back stages. Throughput: one input transaction per
// cycle while the queue is not full, set by the 24 x 14 multiply stage in the back end;
// a 4-entry queue lets the front keep taking items while a result waits on rsp_tready.
// Reset clears the set tracking, the pipeline and the queue, and loads the register
// defaults; the user writes registers only between sets; the block does not enforce it.
module nfa_best_inlier_count_core #(
   parameter int MAX_POINTS = nfa_bic_pkg::MAX_POINTS,
   parameter int POS_W      = $clog2(MAX_POINTS + 1),
   parameter int RSP_W      = ((nfa_bic_pkg::NFA_W + POS_W + 2 + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [nfa_bic_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [nfa_bic_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [nfa_bic_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // error_sq[31:0], log_comb_n[58:32], log_comb_k[85:59], zero pad
   input  logic [nfa_bic_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // side
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found[0], best_nfa[48:1], inlier_count[48+POS_W:49], best_side, zero pad
   output logic [RSP_W-1:0]                     rsp_tdata
);

   localparam int Q_W = nfa_bic_pkg::CTL_W + nfa_bic_pkg::LALPHA_W + POS_W
                        + 2 * nfa_bic_pkg::COMB_W;
   localparam int DW  = nfa_bic_pkg::CSR_DATA_W;

   nfa_bic_pkg::cfg_type cfg_ff, cfg_in;
   logic                 csr_write;
   logic                 q_push, q_full, q_pop, q_empty;
   logic [Q_W-1:0]       q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (nfa_bic_pkg::reg_index_type'(csr_paddr[4:2]))
            nfa_bic_pkg::REG_ALPHA_LEFT:
               cfg_in.alpha_left = csr_pwdata[nfa_bic_pkg::ALPHA_W-1:0];
            nfa_bic_pkg::REG_ALPHA_RIGHT:
               cfg_in.alpha_right = csr_pwdata[nfa_bic_pkg::ALPHA_W-1:0];
            nfa_bic_pkg::REG_HALF_WEIGHT:
               cfg_in.half_weight = csr_pwdata[0];
            nfa_bic_pkg::REG_SAMPLE_SIZE:
               cfg_in.sample_size = csr_pwdata[nfa_bic_pkg::SS_W-1:0];
            nfa_bic_pkg::REG_LOG_E0:
               cfg_in.log_e0 = csr_pwdata[nfa_bic_pkg::E0_W-1:0];
            nfa_bic_pkg::REG_MAX_THRESHOLD:
               cfg_in.max_threshold = csr_pwdata[nfa_bic_pkg::ERR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (nfa_bic_pkg::reg_index_type'(csr_paddr[4:2]))
         nfa_bic_pkg::REG_ALPHA_LEFT:    csr_prdata = DW'(unsigned'(cfg_ff.alpha_left));
         nfa_bic_pkg::REG_ALPHA_RIGHT:   csr_prdata = DW'(unsigned'(cfg_ff.alpha_right));
         nfa_bic_pkg::REG_HALF_WEIGHT:   csr_prdata = DW'(cfg_ff.half_weight);
         nfa_bic_pkg::REG_SAMPLE_SIZE:   csr_prdata = DW'(cfg_ff.sample_size);
         nfa_bic_pkg::REG_LOG_E0:        csr_prdata = DW'(cfg_ff.log_e0);
         nfa_bic_pkg::REG_MAX_THRESHOLD: csr_prdata = DW'(cfg_ff.max_threshold);
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_left    <= nfa_bic_pkg::ALPHA_RESET;
         cfg_ff.alpha_right   <= nfa_bic_pkg::ALPHA_RESET;
         cfg_ff.half_weight   <= nfa_bic_pkg::HALF_RESET;
         cfg_ff.sample_size   <= nfa_bic_pkg::SS_RESET;
         cfg_ff.log_e0        <= nfa_bic_pkg::E0_RESET;
         cfg_ff.max_threshold <= nfa_bic_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nfa_bic_front #(
      .MAX_POINTS (MAX_POINTS),
      .POS_W      (POS_W),
      .Q_W        (Q_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   nfa_bic_queue #(
      .WIDTH (Q_W),
      .DEPTH (nfa_bic_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   nfa_bic_back #(
      .MAX_POINTS (MAX_POINTS),
      .POS_W      (POS_W),
      .Q_W        (Q_W),
      .RSP_W      (RSP_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_rdata    (q_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/nfa_bic_checker.sv =====
`include "nfa_best_inlier_count_core_defines.svh"

module nfa_bic_checker #(
   parameter int MAX_POINTS = nfa_bic_pkg::MAX_POINTS,
   parameter int POS_W      = $clog2(MAX_POINTS + 1),
   parameter int RSP_W      = ((nfa_bic_pkg::NFA_W + POS_W + 2 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             csr_psel,
   input logic             csr_pready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int NFA_W = nfa_bic_pkg::NFA_W;

   logic             rsp_found;
   logic [NFA_W-1:0] rsp_nfa;
   logic [POS_W-1:0] rsp_count;
   logic             rsp_side;

   assign rsp_found = rsp_tdata[0];
   assign rsp_nfa   = rsp_tdata[NFA_W:1];
   assign rsp_count = rsp_tdata[NFA_W+1 +: POS_W];
   assign rsp_side  = rsp_tdata[NFA_W+1+POS_W];

   `NFA_BIC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)

   `NFA_BIC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a set with no evaluated item reports zero cost and left side
   `NFA_BIC_ASSERT_NOW(a_none_zero, rsp_tvalid && !rsp_found, rsp_nfa == '0 && !rsp_side)

   // a found minimum always sits at a position past zero
   `NFA_BIC_ASSERT_NOW(a_found_pos, rsp_tvalid && rsp_found, rsp_count != '0)

   `NFA_BIC_ASSERT_NOW(a_csr_ready, csr_psel, csr_pready)

endmodule

bind nfa_best_inlier_count_core nfa_bic_checker #(
   .MAX_POINTS (MAX_POINTS),
   .POS_W      (POS_W),
   .RSP_W      (RSP_W)
) u_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_DATA_W   = 64;
   localparam int POINTS_CAP   = 4096;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 3000;
   localparam int UNUSED_REG_A = 6;
   localparam int UNUSED_REG_B = 7;

   // residual-set item as it travels on the request stream
   typedef struct {
      logic [31:0] error_sq;
      logic        side;
      logic [26:0] log_comb_n;
      logic [26:0] log_comb_k;
      logic        last;
   } residual_type;

   typedef struct {
      logic        found;
      logic [47:0] best_nfa;
      logic [12:0] inlier_count;
      logic        best_side;
   } minimum_type;

   localparam int LOG_MANTISSA [16] = '{
      0, 1725, 3352, 4891, 6351, 7740, 9064, 10329,
      11540, 12702, 13818, 14893, 15928, 16927, 17891, 18825
   };

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [nfa_bic_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [nfa_bic_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [nfa_bic_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                                csr_pready;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // error_sq[31:0], log_comb_n[58:32], log_comb_k[85:59], zero pad
   logic [nfa_bic_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   // side
   logic                                req_tuser = 1'b0;
   logic                                req_tlast = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // found[0], best_nfa[48:1], inlier_count[61:49], best_side[62], zero pad
   logic [RSP_DATA_W-1:0]               rsp_tdata;

   nfa_best_inlier_count_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // register copies
   longint cfg_alpha_left;
   longint cfg_alpha_right;
   logic   cfg_half_weight;
   int     cfg_sample_size;
   longint cfg_log_e0;
   logic [31:0] cfg_threshold;

   // set tracking
   int     set_position;
   longint set_min_nfa;
   int     set_min_position;
   logic   set_min_side;
   logic   set_have_min;
   logic   set_over_threshold;

   residual_type pending_residuals [$];
   minimum_type  expected_minima [$];
   residual_type drive_item;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;
   int error_count = 0;
   int items_queued = 0;
   int sets_queued = 0;
   int items_sent = 0;
   int results_seen = 0;
   int found_seen = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint log10_fixed(logic [32:0] x);
      int p;
      int i;
      logic [3:0] idx;
      p = 0;
      for (i = 32; i >= 0; i--) begin
         if (x[i]) begin
            p = i;
            break;
         end
      end
      if (p >= 4) begin
         idx = 4'(x >> (p - 4));
      end else begin
         idx = 4'(x << (4 - p));
      end
      return longint'(p - 16) * 19728 + longint'(LOG_MANTISSA[idx]);
   endfunction

   task automatic clear_set_tracking();
      set_position = 0;
      set_min_nfa = 0;
      set_min_position = 0;
      set_min_side = 1'b0;
      set_have_min = 1'b0;
      set_over_threshold = 1'b0;
   endtask

   task automatic apply_register(int idx, logic [31:0] data);
      case (idx)
         nfa_bic_pkg::REG_ALPHA_LEFT:    cfg_alpha_left = longint'($signed(data[22:0]));
         nfa_bic_pkg::REG_ALPHA_RIGHT:   cfg_alpha_right = longint'($signed(data[22:0]));
         nfa_bic_pkg::REG_HALF_WEIGHT:   cfg_half_weight = data[0];
         nfa_bic_pkg::REG_SAMPLE_SIZE:   cfg_sample_size = int'(data[4:0]);
         nfa_bic_pkg::REG_LOG_E0:        cfg_log_e0 = longint'(data[19:0]);
         nfa_bic_pkg::REG_MAX_THRESHOLD: cfg_threshold = data;
         default: ;
      endcase
   endtask

   // advances the running minimum search by one residual
   task automatic update_nfa_search(residual_type r);
      int k;
      longint lg;
      longint alpha;
      longint nfa;
      minimum_type m;
      if (set_position < POINTS_CAP) begin
         k = set_position + 1;
         set_position = k;
         if (r.error_sq > cfg_threshold) set_over_threshold = 1'b1;
         if (!set_over_threshold && k > cfg_sample_size) begin
            lg = log10_fixed({1'b0, r.error_sq} + 33'd1);
            alpha = r.side ? cfg_alpha_right : cfg_alpha_left;
            if (cfg_half_weight) lg = lg >>> 1;
            nfa = cfg_log_e0 + (alpha + lg) * longint'(k - cfg_sample_size)
                  + longint'(r.log_comb_n) + longint'(r.log_comb_k);
            if (nfa > 64'sh0000_7FFF_FFFF_FFFF) nfa = 64'sh0000_7FFF_FFFF_FFFF;
            if (nfa < -64'sh0000_8000_0000_0000) nfa = -64'sh0000_8000_0000_0000;
            if (!set_have_min || nfa < set_min_nfa) begin
               set_have_min = 1'b1;
               set_min_nfa = nfa;
               set_min_position = k;
               set_min_side = r.side;
            end
         end
      end
      if (r.last) begin
         m.found = set_have_min;
         m.best_nfa = set_have_min ? 48'(set_min_nfa) : '0;
         m.inlier_count = set_have_min ? 13'(set_min_position) : 13'(cfg_sample_size);
         m.best_side = set_have_min ? set_min_side : 1'b0;
         expected_minima.push_back(m);
         clear_set_tracking();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
               results_seen, what, got, want);
      error_count++;
   endtask

   function automatic bit idle_now(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_nfa_search(drive_item);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_residuals.size() != 0 && !idle_now(send_idle_pct)) begin
               drive_item = pending_residuals.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, drive_item.log_comb_k, drive_item.log_comb_n,
                             drive_item.error_sq};
               req_tuser <= drive_item.side;
               req_tlast <= drive_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      minimum_type m;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_minima.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, '0);
            end else begin
               m = expected_minima.pop_front();
               if (m.found) found_seen++;
               if (rsp_tdata[0] !== m.found)
                  report_mismatch("found", 64'(rsp_tdata[0]), 64'(m.found));
               if (rsp_tdata[48:1] !== m.best_nfa)
                  report_mismatch("best_nfa", 64'(rsp_tdata[48:1]), 64'(m.best_nfa));
               if (rsp_tdata[61:49] !== m.inlier_count)
                  report_mismatch("inlier_count", 64'(rsp_tdata[61:49]),
                                  64'(m.inlier_count));
               if (rsp_tdata[62] !== m.best_side)
                  report_mismatch("best_side", 64'(rsp_tdata[62]), 64'(m.best_side));
            end
         end
         rsp_tready <= !idle_now(recv_idle_pct);
      end
   end

   // watchdog on stream inactivity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_write(int idx, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= nfa_bic_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      apply_register(idx, data);
   endtask

   task automatic write_settings(int alpha_l, int alpha_r, logic half, int ss,
                                 int unsigned e0, logic [31:0] thr);
      csr_write(nfa_bic_pkg::REG_ALPHA_LEFT, 32'(alpha_l));
      csr_write(nfa_bic_pkg::REG_ALPHA_RIGHT, 32'(alpha_r));
      csr_write(nfa_bic_pkg::REG_HALF_WEIGHT, 32'(half));
      csr_write(nfa_bic_pkg::REG_SAMPLE_SIZE, 32'(ss));
      csr_write(nfa_bic_pkg::REG_LOG_E0, 32'(e0));
      csr_write(nfa_bic_pkg::REG_MAX_THRESHOLD, thr);
   endtask

   task automatic write_random_settings(logic [31:0] thr);
      write_settings(-int'($urandom_range(4194304)), -int'($urandom_range(4194304)),
                     1'($urandom_range(1)), $urandom_range(16, 1),
                     $urandom_range(1048575), thr);
   endtask

   task automatic wait_drained();
      while (pending_residuals.size() != 0 || req_tvalid || expected_minima.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_residual(logic [31:0] err, logic side, logic [26:0] cn,
                                logic [26:0] ck, logic last);
      residual_type r;
      r.error_sq = err;
      r.side = side;
      r.log_comb_n = cn;
      r.log_comb_k = ck;
      r.last = last;
      pending_residuals.push_back(r);
      items_queued++;
      if (last) sets_queued++;
   endtask

   // one residual set, sorted ascending or in random order
   task automatic queue_set(int n, bit ascending);
      logic [31:0] e;
      logic [32:0] s;
      int i;
      e = ($urandom_range(3) == 0) ? 32'd0 : ($urandom >> $urandom_range(31));
      for (i = 0; i < n; i++) begin
         push_residual(ascending ? e : ($urandom >> $urandom_range(31)),
                       1'($urandom_range(1)),
                       27'($urandom) >> $urandom_range(26),
                       27'($urandom) >> $urandom_range(26),
                       i == n - 1);
         s = {1'b0, e} + 33'($urandom >> $urandom_range(31, 2));
         e = s[32] ? 32'hFFFF_FFFF : s[31:0];
      end
   endtask

   task automatic queue_random_sets(int budget, int max_len);
      int start;
      int n;
      start = items_queued;
      while (items_queued - start < budget) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(max_len, 1) : $urandom_range(20, 1);
         queue_set(n, $urandom_range(9) != 0);
      end
   endtask

   initial begin
      int i;
      cfg_alpha_left = -262144;
      cfg_alpha_right = -262144;
      cfg_half_weight = 1'b1;
      cfg_sample_size = 7;
      cfg_log_e0 = 131072;
      cfg_threshold = 32'hFFFF_FFFF;
      clear_set_tracking();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily; reset register values
      send_idle_pct = 25;
      recv_idle_pct = 86;
      // lone last item: nothing evaluated
      push_residual(32'd0, 1'b0, 27'd0, 27'd0, 1'b1);
      // ascending set covering residual extremes and full table values
      push_residual(32'd0, 1'b0, 27'd0, 27'd0, 1'b0);
      push_residual(32'd0, 1'b1, 27'd0, 27'd0, 1'b0);
      push_residual(32'd1, 1'b0, 27'd1, 27'd1, 1'b0);
      push_residual(32'h10, 1'b1, 27'd100, 27'd5, 1'b0);
      push_residual(32'h100, 1'b0, 27'h7FF_FFFF, 27'd0, 1'b0);
      push_residual(32'h1_0000, 1'b1, 27'd0, 27'h7FF_FFFF, 1'b0);
      push_residual(32'h7FFF_FFFF, 1'b0, 27'd3, 27'd3, 1'b0);
      push_residual(32'h8000_0000, 1'b1, 27'h7FF_FFFF, 27'h7FF_FFFF, 1'b0);
      push_residual(32'hFFFF_FFFF, 1'b0, 27'h7FF_FFFF, 27'h7FF_FFFF, 1'b0);
      push_residual(32'hFFFF_FFFF, 1'b1, 27'h7FF_FFFF, 27'h7FF_FFFF, 1'b1);
      // descending residuals: no order check in the block
      for (i = 0; i < 10; i++)
         push_residual(32'hFFFF_FFFF >> (3 * i), i[0], 27'(i * 1000), 27'h2AA_AAAA,
                       i == 9);
      queue_random_sets(200, 40);
      wait_drained();

      // sample size zero, full-weight log, extreme alphas and e0
      write_settings(-4194304, 0, 1'b0, 0, 1048575, $urandom >> $urandom_range(12));
      csr_write(UNUSED_REG_A, $urandom);
      csr_write(UNUSED_REG_B, $urandom);
      queue_random_sets(250, 40);
      wait_drained();

      // other way round on idling; largest sample size, no threshold
      send_idle_pct = 86;
      recv_idle_pct = 25;
      write_settings(0, -4194304, 1'b1, 31, 0, 32'hFFFF_FFFF);
      queue_random_sets(250, 60);
      wait_drained();

      // zero threshold: only zero residuals before the first nonzero one are considered
      write_settings(-int'($urandom_range(4194304)), -int'($urandom_range(4194304)),
                     1'b0, 1, $urandom_range(1048575), 32'd0);
      queue_random_sets(250, 30);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_random_settings($urandom >> $urandom_range(16));
      queue_random_sets(300, 40);
      wait_drained();

      // random register values with no threshold
      write_random_settings(32'hFFFF_FFFF);
      queue_random_sets(300, 40);
      wait_drained();

      $display("Ran %0d residuals in %0d sets across six register settings",
               items_sent, sets_queued);
      $display("%0d sets reported a minimum, %0d reported none",
               found_seen, results_seen - found_seen);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/nfa_bic_pkg.sv
hdl/nfa_bic_front.sv
hdl/nfa_bic_queue.sv
hdl/nfa_bic_back.sv
hdl/nfa_best_inlier_count_core.sv
hdl/nfa_bic_checker.sv
tb/testbench.sv
